// ===== rtl/sfb_pkg.sv =====
// ----------------------------------------------------------------------------
// sfb_pkg: shared types and constants for the sensor frame builder
// Frame layout indexes, CRC-16/Modbus step function and queue status type.
// ----------------------------------------------------------------------------
package sfb_pkg;

  localparam int FRAME_LEN     = 36;
  localparam int PAYLOAD_BYTES = 33;
  localparam int QUEUE_DEPTH   = 2;

  typedef logic [5:0] byte_idx_t;

  // Byte positions within a frame
  localparam byte_idx_t IDX_SYNC      = 6'd0;
  localparam byte_idx_t IDX_CRC_FIRST = 6'd1;
  localparam byte_idx_t IDX_CRC_LAST  = 6'd33;
  localparam byte_idx_t IDX_CRC_LO    = 6'd34;
  localparam byte_idx_t IDX_CRC_HI    = 6'd35;

  localparam logic [7:0]  SYNC_RESET = 8'd121;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;

  // Frame bytes 1..33, element 0 is frame byte 1
  typedef logic [PAYLOAD_BYTES-1:0][7:0] payload_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } queue_status_t;

  // One byte of reflected CRC-16/Modbus
  function automatic logic [15:0] crc_byte(logic [15:0] crc_in, logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/sensor_frame_builder_crc16_unit.sv =====
// ----------------------------------------------------------------------------
// sensor_frame_builder_crc16_unit: sensor sample framer with CRC-16/Modbus
// Turns each sample set into a 36-byte frame, one byte per output item.
// ----------------------------------------------------------------------------
// Path: an accepted item is written to the queue, loaded into the serializer,
// and its first byte is then registered onto the output.
// The byte-wide output serializer sends one frame at a time;
// a queue of QUEUE_DEPTH sample sets absorbs input while a frame is sent.
// Reset: queue empty, held range 0, sync byte 121.
module sensor_frame_builder_crc16_unit #(
  parameter int QUEUE_DEPTH = sfb_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        range_new,
  input  logic [15:0] range_value,
  input  logic [63:0] flow_low_bytes,
  input  logic [47:0] flow_high_bytes,
  input  logic [63:0] pressure_bits,
  input  logic [63:0] temperature_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  frame_byte,
  output logic        frame_end
);
  import sfb_pkg::*;

  logic [7:0]    sync_byte;
  queue_status_t q_status;
  logic          push;
  logic          pop;
  payload_t      push_data;
  payload_t      q_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_byte <= SYNC_RESET;
    end else if (cfg_valid && cfg_ready) begin
      sync_byte <= cfg_data;
    end
  end

  sfb_front u_front (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .range_new        (range_new),
    .range_value      (range_value),
    .flow_low_bytes   (flow_low_bytes),
    .flow_high_bytes  (flow_high_bytes),
    .pressure_bits    (pressure_bits),
    .temperature_bits (temperature_bits),
    .q_status         (q_status),
    .push             (push),
    .push_data        (push_data)
  );

  sfb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (q_data),
    .status    (q_status)
  );

  sfb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .sync_byte  (sync_byte),
    .q_status   (q_status),
    .q_data     (q_data),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .frame_byte (frame_byte),
    .frame_end  (frame_end)
  );

endmodule

// ===== rtl/sfb_front.sv =====
// ----------------------------------------------------------------------------
// sfb_front: input side of the frame builder
// Accepts sample sets, tracks the held range and packs frame bytes 1..33.
// ----------------------------------------------------------------------------
module sfb_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  range_new,
  input  logic [15:0]           range_value,
  input  logic [63:0]           flow_low_bytes,
  input  logic [47:0]           flow_high_bytes,
  input  logic [63:0]           pressure_bits,
  input  logic [63:0]           temperature_bits,
  input  sfb_pkg::queue_status_t q_status,
  output logic                  push,
  output sfb_pkg::payload_t     push_data
);
  import sfb_pkg::*;

  logic [15:0] held_range;
  logic [15:0] range_sel;

  assign in_stall  = q_status.full;
  assign push      = in_valid && !q_status.full;
  assign range_sel = range_new ? range_value : held_range;

  assign push_data = {temperature_bits, pressure_bits, flow_high_bytes, flow_low_bytes,
                      range_sel[7:0], range_sel[15:8], 7'd0, range_new};

  always_ff @(posedge clk) begin
    if (rst) begin
      held_range <= 16'd0;
    end else if (push && range_new) begin
      held_range <= range_value;
    end
  end

endmodule

// ===== rtl/sfb_queue.sv =====
// ----------------------------------------------------------------------------
// sfb_queue: short item queue between front and back
// Circular buffer of packed frame payloads with an occupancy count.
// ----------------------------------------------------------------------------
module sfb_queue #(
  parameter int DEPTH = sfb_pkg::QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  sfb_pkg::payload_t      push_data,
  input  logic                   pop,
  output sfb_pkg::payload_t      pop_data,
  output sfb_pkg::queue_status_t status
);
  import sfb_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  payload_t         entries [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign status.not_empty = (count != '0);
  assign status.full      = (count == CW'(DEPTH));
  assign pop_data         = entries[rd_ptr];

  function automatic logic [AW-1:0] ptr_inc(logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/sfb_back.sv =====
// ----------------------------------------------------------------------------
// sfb_back: frame serializer
// Sends one frame byte per cycle unless stalled, folds bytes 1..33 into the CRC, appends it.
// ----------------------------------------------------------------------------
module sfb_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [7:0]             sync_byte,
  input  sfb_pkg::queue_status_t q_status,
  input  sfb_pkg::payload_t      q_data,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [7:0]             frame_byte,
  output logic                   frame_end
);
  import sfb_pkg::*;

  payload_t    payload;
  logic        busy;
  byte_idx_t   idx;
  byte_idx_t   pidx;
  logic [15:0] crc;
  logic [7:0]  byte_sel;
  logic        advance;
  logic        last;

  assign advance = !out_valid || !out_stall;
  assign last    = busy && (idx == IDX_CRC_HI);
  assign pop     = advance && q_status.not_empty && (!busy || last);

  always_comb begin
    pidx = idx - IDX_CRC_FIRST;
    case (idx)
      IDX_SYNC:   byte_sel = sync_byte;
      IDX_CRC_LO: byte_sel = crc[7:0];
      IDX_CRC_HI: byte_sel = crc[15:8];
      default:    byte_sel = payload[pidx];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
      idx       <= IDX_SYNC;
      crc       <= CRC_INIT;
    end else if (advance) begin
      out_valid <= busy;
      if (busy) begin
        frame_byte <= byte_sel;
        frame_end  <= last;
      end
      // load the next frame right behind the last byte of this one
      if (pop) begin
        payload <= q_data;
        busy    <= 1'b1;
        idx     <= IDX_SYNC;
        crc     <= CRC_INIT;
      end else if (busy) begin
        idx <= idx + 1'b1;
        if (idx inside {[IDX_CRC_FIRST:IDX_CRC_LAST]}) begin
          crc <= crc_byte(crc, byte_sel);
        end
        if (last) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== rtl/sfb_checker.sv =====
// ----------------------------------------------------------------------------
// sfb_checker: port-level checks for the sensor frame builder
// Tracks frame position and sync byte from the ports and checks the output.
// ----------------------------------------------------------------------------
module sfb_checker (
  input logic        clk,
  input logic        rst,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [7:0]  cfg_data,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  frame_byte,
  input logic        frame_end
);
  import sfb_pkg::*;

  byte_idx_t  pos;
  logic [7:0] sync_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= IDX_SYNC;
      sync_seen <= SYNC_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        sync_seen <= cfg_data;
      end
      if (out_valid && !out_stall) begin
        pos <= (pos == IDX_CRC_HI) ? IDX_SYNC : pos + 1'b1;
      end
    end
  end

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(frame_byte) && $stable(frame_end))
    else $error("output item changed while stalled");

  a_end_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (frame_end == (pos == IDX_CRC_HI)))
    else $error("frame_end not on the last byte of a frame");

  a_sync_first: assert property (@(posedge clk) disable iff (rst)
    out_valid && (pos == IDX_SYNC) |-> (frame_byte == sync_seen))
    else $error("frame does not open with the sync byte");

endmodule

bind sensor_frame_builder_crc16_unit sfb_checker u_sfb_checker (
  .clk        (clk),
  .rst        (rst),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready),
  .cfg_data   (cfg_data),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .frame_byte (frame_byte),
  .frame_end  (frame_end)
);

// ===== test/sfb_frame_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfb_frame_checker: frame predictor and byte checker for the frame builder
// Watches the config, sample and byte channels, builds the expected 36-byte
// frame with its CRC-16/Modbus for every accepted item, and compares each
// byte that leaves the block against the oldest expected one.
// ----------------------------------------------------------------------------
module sfb_frame_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        range_new,
  input  logic [15:0] range_value,
  input  logic [63:0] flow_low_bytes,
  input  logic [47:0] flow_high_bytes,
  input  logic [63:0] pressure_bits,
  input  logic [63:0] temperature_bits,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  frame_byte,
  input  logic        frame_end,
  output int          mismatch_count,
  output int          bytes_outstanding
);
  import sfb_pkg::*;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } frame_byte_t;

  frame_byte_t expected_bytes[$];
  logic [7:0]  sync_value;
  logic [15:0] held_range;

  initial begin
    mismatch_count    = 0;
    bytes_outstanding = 0;
    sync_value        = SYNC_RESET;
    held_range        = 16'h0000;
  end

  // Reflected CRC-16/Modbus, one data bit at a time
  function automatic logic [15:0] crc16_modbus(input logic [15:0] crc, input logic [7:0] data);
    logic feedback;
    for (int b = 0; b < 8; b++) begin
      feedback = crc[0] ^ data[b];
      crc = crc >> 1;
      if (feedback) begin
        crc = crc ^ CRC_POLY;
      end
    end
    return crc;
  endfunction

  function automatic void predict_frame();
    logic [7:0]  frame [FRAME_LEN];
    logic [15:0] crc;
    frame_byte_t entry;
    // latch a fresh range, otherwise repeat the held one
    if (range_new) begin
      held_range = range_value;
    end
    frame[IDX_SYNC] = sync_value;
    frame[1] = {7'd0, range_new};
    frame[2] = held_range[15:8];
    frame[3] = held_range[7:0];
    for (int i = 0; i < 8; i++) begin
      frame[4 + i]  = flow_low_bytes[8*i +: 8];
      frame[18 + i] = pressure_bits[8*i +: 8];
      frame[26 + i] = temperature_bits[8*i +: 8];
    end
    for (int i = 0; i < 6; i++) begin
      frame[12 + i] = flow_high_bytes[8*i +: 8];
    end
    crc = CRC_INIT;
    for (int i = IDX_CRC_FIRST; i <= IDX_CRC_LAST; i++) begin
      crc = crc16_modbus(crc, frame[i]);
    end
    frame[IDX_CRC_LO] = crc[7:0];
    frame[IDX_CRC_HI] = crc[15:8];
    for (int i = 0; i < FRAME_LEN; i++) begin
      entry.value = frame[i];
      entry.last  = (i == FRAME_LEN - 1);
      expected_bytes.push_back(entry);
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] want,
                                 input logic [7:0] got);
    if (mismatch_count < 100) begin
      $display("%0t ns: %s mismatch: expected %02h, got %02h", $time, what, want, got);
    end
    mismatch_count++;
  endtask

  always @(posedge clk) begin : monitor
    frame_byte_t want;
    if (rst) begin
      sync_value = SYNC_RESET;
      held_range = 16'h0000;
      expected_bytes.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch("unexpected frame byte", 8'h00, frame_byte);
        end else begin
          want = expected_bytes.pop_front();
          if (frame_byte !== want.value) begin
            report_mismatch("frame_byte", want.value, frame_byte);
          end
          if (frame_end !== want.last) begin
            report_mismatch("frame_end", {7'd0, want.last}, {7'd0, frame_end});
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        sync_value = cfg_data;
      end
      if (in_valid && !in_stall) begin
        predict_frame();
      end
    end
    bytes_outstanding = expected_bytes.size();
  end

endmodule

// ===== test/sensor_frame_builder_crc16_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_frame_builder_crc16_unit_test: stimulus and verdict for the framer
// Sends directed and random sample sets under changing sync bytes and idle
// patterns on both channels, including a long output hold that backs up the
// input; a side checker predicts and compares every frame byte.
// ----------------------------------------------------------------------------
module sensor_frame_builder_crc16_unit_test;

  typedef struct packed {
    logic        range_new;
    logic [15:0] range_value;
    logic [63:0] flow_low;
    logic [47:0] flow_high;
    logic [63:0] pressure;
    logic [63:0] temperature;
  } sample_set_t;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic        range_new;
  logic [15:0] range_value;
  logic [63:0] flow_low_bytes;
  logic [47:0] flow_high_bytes;
  logic [63:0] pressure_bits;
  logic [63:0] temperature_bits;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  frame_byte;
  logic        frame_end;

  int mismatch_count;
  int bytes_outstanding;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_requests;

  sensor_frame_builder_crc16_unit u_top (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .range_new        (range_new),
    .range_value      (range_value),
    .flow_low_bytes   (flow_low_bytes),
    .flow_high_bytes  (flow_high_bytes),
    .pressure_bits    (pressure_bits),
    .temperature_bits (temperature_bits),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .frame_byte       (frame_byte),
    .frame_end        (frame_end)
  );

  sfb_frame_checker u_checker (
    .clk               (clk),
    .rst               (rst),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .range_new         (range_new),
    .range_value       (range_value),
    .flow_low_bytes    (flow_low_bytes),
    .flow_high_bytes   (flow_high_bytes),
    .pressure_bits     (pressure_bits),
    .temperature_bits  (temperature_bits),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .frame_byte        (frame_byte),
    .frame_end         (frame_end),
    .mismatch_count    (mismatch_count),
    .bytes_outstanding (bytes_outstanding)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Byte receiver: random stalls, plus a long hold on request
  initial begin : receiver
    int hold_left;
    int holds_served;
    hold_left    = 0;
    holds_served = 0;
    out_stall    = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        hold_left    = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  initial begin : time_limit
    #4_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [63:0] pick_word();
    case ($urandom_range(7))
      0:       return 64'h0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic sample_set_t random_sample();
    sample_set_t s;
    s.range_new   = 1'($urandom_range(1));
    s.range_value = 16'(pick_word());
    s.flow_low    = pick_word();
    s.flow_high   = 48'(pick_word());
    s.pressure    = pick_word();
    s.temperature = pick_word();
    return s;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic offer_sample(input sample_set_t s);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid         <= 1'b1;
    range_new        <= s.range_new;
    range_value      <= s.range_value;
    flow_low_bytes   <= s.flow_low;
    flow_high_bytes  <= s.flow_high;
    pressure_bits    <= s.pressure;
    temperature_bits <= s.temperature;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Stop offering and wait until every expected byte has left the block
  task automatic drain_frames();
    in_valid <= 1'b0;
    while (bytes_outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_sync_byte(input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic [7:0] sync_settings [3];
    rst              = 1'b1;
    cfg_valid        = 1'b0;
    cfg_data         = 8'h00;
    in_valid         = 1'b0;
    range_new        = 1'b0;
    range_value      = 16'h0000;
    flow_low_bytes   = 64'h0;
    flow_high_bytes  = 48'h0;
    pressure_bits    = 64'h0;
    temperature_bits = 64'h0;
    send_idle_pct    = 23;
    recv_idle_pct    = 56;
    hold_requests    = 0;
    sync_settings[0] = 8'h00;
    sync_settings[1] = 8'hFF;
    sync_settings[2] = 8'($urandom_range(1, 254));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset sync byte; stale range before any reading must be zero
    offer_sample('{1'b0, 16'h0000, 64'h0, 48'h0, 64'h0, 64'h0});
    offer_sample('{1'b0, 16'hFFFF, '1, '1, '1, '1});
    offer_sample('{1'b1, 16'hFFFF, '1, '1, '1, '1});
    offer_sample('{1'b0, 16'h0000, 64'h0, 48'h0, 64'h0, 64'h0});
    offer_sample('{1'b0, 16'h1234, 64'h0, 48'h0, 64'h0, 64'h0});
    offer_sample('{1'b1, 16'h0000, 64'h0, 48'h0, 64'h0, 64'h0});
    offer_sample('{1'b1, 16'h8001, 64'h0123_4567_89AB_CDEF, 48'hFEDC_BA98_7654,
                   64'h8000_0000_0000_0001, 64'h7FFF_FFFF_FFFF_FFFE});
    offer_sample('{1'b0, 16'h5555, 64'hAAAA_AAAA_AAAA_AAAA, 48'h5555_5555_5555,
                   64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA});
    offer_sample('{1'b1, 16'h00FF, 64'h0, 48'hFFFF_FFFF_FFFF, 64'h0, '1});
    offer_sample('{1'b1, 16'hFF00, '1, 48'h0, '1, 64'h0});

    for (int phase = 0; phase < 3; phase++) begin
      drain_frames();
      write_sync_byte(sync_settings[phase]);
      send_idle_pct = (phase == 0) ? 23 : (phase == 1) ? 56 : 0;
      recv_idle_pct = (phase == 0) ? 56 : (phase == 1) ? 23 : 0;
      for (int n = 0; n < 137; n++) begin
        // hold the byte side long enough for the sample queue to fill up
        if (phase == 0 && n == 20) begin
          hold_requests++;
        end
        offer_sample(random_sample());
      end
    end

    drain_frames();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/sfb_pkg.sv
rtl/sfb_front.sv
rtl/sfb_queue.sv
rtl/sfb_back.sv
rtl/sensor_frame_builder_crc16_unit.sv
rtl/sfb_checker.sv
test/sfb_frame_checker.sv
test/sensor_frame_builder_crc16_unit_test.sv
